@@ hdl/rau_pkg.sv @@
package rau_pkg;

	localparam int RES_W = 64;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_NEG   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_RECIP = 4'd5,
		OP_LT    = 4'd6,
		OP_LE    = 4'd7,
		OP_GT    = 4'd8,
		OP_GE    = 4'd9,
		OP_EQ    = 4'd10,
		OP_NE    = 4'd11,
		OP_GCD   = 4'd12
	} op_t;

	// operand pairs fed to the shared multiplier
	typedef enum logic [2:0] {
		MP_AN_BD,
		MP_BN_AD,
		MP_AD_BD,
		MP_AN_BN,
		MP_AD_BN
	} mpair_t;

	typedef enum logic [1:0] {
		SL_P0,
		SL_P1,
		SL_P2
	} slot_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DIVZERO  = 2'd1,
		ST_OVERFLOW = 2'd2
	} st_t;

	typedef struct packed {
		logic   load;
		logic   mul_go;
		mpair_t mpair;
		slot_t  slot;
		logic   gcd_step;
		logic   fin;
		op_t    op;
	} cmd_t;

	typedef struct packed {
		logic eq_den;
		logic gcd_done;
	} stat_t;

endpackage

@@ hdl/rational_arith_unit.sv @@
// Rational ALU taking one request at a time: a request is taken when start is high and busy is
// low, and its result appears on the result ports for exactly one cycle with done high; the
// receiver cannot stall it, so capture it on that cycle. After acceptance, negate, reciprocal
// and unused codes go straight to the finish state; add/subtract with equal denominators pass
// through MUL0; multiply, divide and the comparisons through MUL0 and MUL1; and add/subtract
// with unequal denominators through MUL0, MUL1 and MUL2: one shared OPERAND_WIDTH-square
// multiplier forms the cross products one per cycle. The gcd runs a binary gcd loop at one
// step per cycle, at most 2*OPERAND_WIDTH-1 steps, before the finish state. busy is already
// low in the strobe cycle, so a new request may be taken there.
module rational_arith_unit #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [3:0]                       req_type,
	input  logic signed [31:0]               a_num,
	input  logic signed [31:0]               a_den,
	input  logic signed [31:0]               b_num,
	input  logic signed [31:0]               b_den,
	output logic                             done,
	output logic signed [rau_pkg::RES_W-1:0] res_num,
	output logic signed [rau_pkg::RES_W-1:0] res_den,
	output logic                             cmp_true,
	output logic [1:0]                       status
);

	rau_pkg::cmd_t  cmd;
	rau_pkg::stat_t stat;

	rau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	rau_dpath #(
		.W (OPERAND_WIDTH)
	) u_dpath (
		.clk      (clk),
		.cmd      (cmd),
		.a_num    (a_num),
		.a_den    (a_den),
		.b_num    (b_num),
		.b_den    (b_den),
		.stat     (stat),
		.res_num  (res_num),
		.res_den  (res_den),
		.cmp_true (cmp_true),
		.status   (status)
	);

endmodule

@@ hdl/rau_dpath.sv @@
module rau_dpath #(
	parameter int W = 32
) (
	input  logic                            clk,
	input  rau_pkg::cmd_t                   cmd,
	input  logic [31:0]                     a_num,
	input  logic [31:0]                     a_den,
	input  logic [31:0]                     b_num,
	input  logic [31:0]                     b_den,
	output rau_pkg::stat_t                  stat,
	output logic signed [rau_pkg::RES_W-1:0] res_num,
	output logic signed [rau_pkg::RES_W-1:0] res_den,
	output logic                            cmp_true,
	output logic [1:0]                      status
);

	localparam int PW = 2 * W;
	localparam int KW = $clog2(W);
	localparam int XW = rau_pkg::RES_W + 1;

	logic signed [W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic signed [PW-1:0] p0_q, p1_q, p2_q;
	logic [W-1:0]         gx_q, gy_q;
	logic [KW-1:0]        k_q;

	logic signed [W-1:0]  ma, mb;
	logic signed [PW-1:0] prod;

	logic                 sub;
	logic signed [XW-1:0] xl, xr, xs;
	logic signed [W:0]    nsum, nneg;
	logic [W-1:0]         gval;
	logic                 lt, eq;

	logic signed [rau_pkg::RES_W-1:0] rn, rd;
	logic                             cmp;
	rau_pkg::st_t                     st;

	logic signed [rau_pkg::RES_W-1:0] res_num_q, res_den_q;
	logic                             cmp_q;
	rau_pkg::st_t                     st_q;

	function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	assign stat.eq_den   = (ad_q == bd_q);
	assign stat.gcd_done = (gx_q == '0) || (gy_q == '0);

	always_comb begin
		unique case (cmd.mpair)
			rau_pkg::MP_AN_BD: begin ma = an_q; mb = bd_q; end
			rau_pkg::MP_BN_AD: begin ma = bn_q; mb = ad_q; end
			rau_pkg::MP_AD_BD: begin ma = ad_q; mb = bd_q; end
			rau_pkg::MP_AN_BN: begin ma = an_q; mb = bn_q; end
			rau_pkg::MP_AD_BN: begin ma = ad_q; mb = bn_q; end
			default:           begin ma = an_q; mb = bd_q; end
		endcase
	end

	assign prod = ma * mb;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			an_q <= a_num[W-1:0];
			ad_q <= a_den[W-1:0];
			bn_q <= b_num[W-1:0];
			bd_q <= b_den[W-1:0];
			gx_q <= mag_f(a_num[W-1:0]);
			gy_q <= mag_f(b_num[W-1:0]);
			k_q  <= '0;
		end else if (cmd.gcd_step && !stat.gcd_done) begin
			// binary gcd: strip common twos, strip twos from a single even value, then halve the difference of odd values
			unique case ({gx_q[0], gy_q[0]})
				2'b00: begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
					k_q  <= k_q + 1'b1;
				end
				2'b10: gy_q <= gy_q >> 1;
				2'b01: gx_q <= gx_q >> 1;
				default: begin
					if (gx_q >= gy_q) begin
						gx_q <= (gx_q - gy_q) >> 1;
					end else begin
						gy_q <= (gy_q - gx_q) >> 1;
					end
				end
			endcase
		end
		if (cmd.mul_go) begin
			unique case (cmd.slot)
				rau_pkg::SL_P0: p0_q <= prod;
				rau_pkg::SL_P1: p1_q <= prod;
				default:        p2_q <= prod;
			endcase
		end
		if (cmd.fin) begin
			res_num_q <= rn;
			res_den_q <= rd;
			cmp_q     <= cmp;
			st_q      <= st;
		end
	end

	// one shared wide adder: cross sum, cross difference and compare
	always_comb begin
		sub  = (cmd.op != rau_pkg::OP_ADD);
		xl   = XW'(p0_q);
		xr   = XW'(p1_q);
		xs   = xl + (sub ? ~xr : xr) + XW'(sub);
		lt   = xs[XW-1];
		eq   = (p0_q == p1_q);
		nsum = sub ? ((W+1)'(an_q) - (W+1)'(bn_q)) : ((W+1)'(an_q) + (W+1)'(bn_q));
		nneg = -((W+1)'(an_q));
		gval = (gx_q | gy_q) << k_q;
	end

	always_comb begin
		rn  = '0;
		rd  = '0;
		cmp = 1'b0;
		st  = rau_pkg::ST_OK;
		unique case (cmd.op)
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				if (stat.eq_den) begin
					rn = rau_pkg::RES_W'(nsum);
					rd = rau_pkg::RES_W'(ad_q);
				end else if (xs[XW-1] != xs[XW-2]) begin
					st = rau_pkg::ST_OVERFLOW;
				end else begin
					rn = xs[XW-2:0];
					rd = rau_pkg::RES_W'(p2_q);
				end
			end
			rau_pkg::OP_NEG: begin
				rn = rau_pkg::RES_W'(nneg);
				rd = rau_pkg::RES_W'(ad_q);
			end
			rau_pkg::OP_MUL: begin
				rn = rau_pkg::RES_W'(p0_q);
				rd = rau_pkg::RES_W'(p1_q);
			end
			rau_pkg::OP_DIV: begin
				if (p1_q == '0) begin
					st = rau_pkg::ST_DIVZERO;
				end else begin
					rn = rau_pkg::RES_W'(p0_q);
					rd = rau_pkg::RES_W'(p1_q);
				end
			end
			rau_pkg::OP_RECIP: begin
				rn = rau_pkg::RES_W'(ad_q);
				rd = rau_pkg::RES_W'(an_q);
			end
			rau_pkg::OP_LT:  cmp = lt;
			rau_pkg::OP_LE:  cmp = lt || eq;
			rau_pkg::OP_GT:  cmp = !lt && !eq;
			rau_pkg::OP_GE:  cmp = !lt;
			rau_pkg::OP_EQ:  cmp = eq;
			rau_pkg::OP_NE:  cmp = !eq;
			rau_pkg::OP_GCD: rn = {{(rau_pkg::RES_W-W){1'b0}}, gval};
			default: begin
				rn = '0;
			end
		endcase
	end

	assign res_num  = res_num_q;
	assign res_den  = res_den_q;
	assign cmp_true = cmp_q;
	assign status   = st_q;

endmodule

@@ hdl/rau_ctrl.sv @@
module rau_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [3:0]     req_type,
	input  rau_pkg::stat_t stat,
	output rau_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_GCD,
		S_FIN
	} state_t;

	state_t       state_q;
	rau_pkg::op_t op_q;
	rau_pkg::op_t op_in;
	logic         done_q;
	logic         is_addsub;

	assign op_in     = rau_pkg::op_t'(req_type);
	assign is_addsub = (op_q == rau_pkg::OP_ADD) || (op_q == rau_pkg::OP_SUB);
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;

	always_comb begin
		cmd.load     = 1'b0;
		cmd.mul_go   = 1'b0;
		cmd.mpair    = rau_pkg::MP_AN_BD;
		cmd.slot     = rau_pkg::SL_P0;
		cmd.gcd_step = 1'b0;
		cmd.fin      = 1'b0;
		cmd.op       = op_q;
		unique case (state_q)
			S_IDLE: cmd.load = start;
			S_MUL0: begin
				cmd.mul_go = 1'b1;
				cmd.slot   = rau_pkg::SL_P0;
				cmd.mpair  = (op_q == rau_pkg::OP_MUL) ? rau_pkg::MP_AN_BN
				                                       : rau_pkg::MP_AN_BD;
			end
			S_MUL1: begin
				cmd.mul_go = 1'b1;
				cmd.slot   = rau_pkg::SL_P1;
				priority if (op_q == rau_pkg::OP_MUL) begin
					cmd.mpair = rau_pkg::MP_AD_BD;
				end else if (op_q == rau_pkg::OP_DIV) begin
					cmd.mpair = rau_pkg::MP_AD_BN;
				end else begin
					cmd.mpair = rau_pkg::MP_BN_AD;
				end
			end
			S_MUL2: begin
				cmd.mul_go = 1'b1;
				cmd.slot   = rau_pkg::SL_P2;
				cmd.mpair  = rau_pkg::MP_AD_BD;
			end
			S_GCD: cmd.gcd_step = 1'b1;
			S_FIN: cmd.fin = 1'b1;
			default: cmd.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= rau_pkg::OP_ADD;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= op_in;
						unique case (op_in)
							rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL,
							rau_pkg::OP_DIV, rau_pkg::OP_LT, rau_pkg::OP_LE,
							rau_pkg::OP_GT, rau_pkg::OP_GE, rau_pkg::OP_EQ,
							rau_pkg::OP_NE:  state_q <= S_MUL0;
							rau_pkg::OP_GCD: state_q <= S_GCD;
							default:         state_q <= S_FIN;
						endcase
					end
				end
				S_MUL0: begin
					// equal denominators: add or subtract the numerators directly
					if (is_addsub && stat.eq_den) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= is_addsub ? S_MUL2 : S_FIN;
				S_MUL2: state_q <= S_FIN;
				S_GCD: begin
					if (stat.gcd_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
